### rtl/core/ubp_pkg.sv
// Package for the serial bootloader host: codes, widths, phases and the
// front-to-back request record. No dependencies.
package ubp_pkg;

    localparam int PacketBytes = 256;
    localparam int PktW = $clog2(PacketBytes);
    localparam int LenW = PktW + 1;
    localparam int OfsW = 21;

    localparam logic [7:0] AckCode  = 8'h79;
    localparam logic [7:0] NackCode = 8'h1F;
    localparam logic [7:0] SyncCode = 8'h7F;
    localparam logic [7:0] EraseCmd = 8'h43;
    localparam logic [7:0] EraseCmdX = 8'hBC;
    localparam logic [7:0] EraseAll = 8'hFF;
    localparam logic [7:0] EraseAllX = 8'h00;
    localparam logic [7:0] WriteCmd = 8'h31;
    localparam logic [7:0] WriteCmdX = 8'hCE;
    localparam logic [7:0] GoCmd = 8'h21;
    localparam logic [7:0] GoCmdX = 8'hDE;
    localparam logic [7:0] PadByte = 8'hFF;

    localparam logic [15:0] ToShort = 16'd100;
    localparam logic [15:0] ToErase = 16'd2000;
    localparam logic [15:0] ToAddr  = 16'd300;
    localparam logic [15:0] ToData  = 16'd50000;
    localparam logic [15:0] ToLast  = 16'd20000;

    localparam logic [1:0] RegBase  = 2'd0;
    localparam logic [1:0] RegSize  = 2'd1;
    localparam logic [1:0] RegRetry = 2'd2;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_REPLY = 2'd2,
        MODE_IMAGE = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        PH_STOP   = 4'd0,
        PH_SYNC   = 4'd1,
        PH_ERASE  = 4'd2,
        PH_EDONE  = 4'd3,
        PH_WCMD   = 4'd4,
        PH_ADDR   = 4'd5,
        PH_DATA   = 4'd6,
        PH_DACK   = 4'd7,
        PH_GO     = 4'd8
    } phase_t;

    // One run of up to 8 bytes to send plus the status after the item.
    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [3:0]      count;     // 0 means a single empty result
        logic            boot0;
        logic            pulse;
        logic            want;
        logic [3:0]      phase;
        logic            fault;
        logic            conn;
    } run_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       last_of_run;
        logic       boot0_level;
        logic       reset_pulse;
        logic       want_image;
        logic [3:0] phase;
        logic       fault;
        logic       connected;
    } res_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] reply_byte;
        logic [7:0] image_byte;
    } item_t;

endpackage

### rtl/core/ubp_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing; the payload type is a parameter of the interface.
interface ubp_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ubp_front.sv
// Front part: sequencer state, classifies each item and builds its run.
// Depends on ubp_pkg.
module ubp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ubp_pkg::item_t         in_item,
    output logic                   run_valid,
    input  logic                   run_ready,
    output ubp_pkg::run_t          run_data
);
    logic [31:0] base_reg;
    logic [ubp_pkg::OfsW-1:0] size_reg;
    logic [2:0] retry_reg;
    logic [3:0] step_reg, step_next;
    logic [15:0] to_reg, to_next;
    logic [2:0] att_reg, att_next;
    logic [ubp_pkg::OfsW-1:0] ofs_reg, ofs_next;
    logic [7:0] xor_reg, xor_next;
    logic [8:0] left_reg, left_next;
    logic link_reg, link_next, fail_reg, fail_next, boot_reg, boot_next;
    ubp_pkg::run_t r;
    logic go;
    logic [31:0] addr;
    logic [ubp_pkg::OfsW-1:0] rem, ofs1;
    logic [ubp_pkg::LenW-1:0] len, plen;
    logic [1:0] pad;
    logic [7:0] x;
    logic [8:0] left1;

    assign in_ready = run_ready;
    assign go = in_valid && in_ready;
    assign run_valid = in_valid;
    assign run_data = r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 32'h0800_0000;
            size_reg <= '0;
            retry_reg <= 3'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ubp_pkg::RegBase:  base_reg <= cfg_data;
                ubp_pkg::RegSize:  size_reg <= cfg_data[ubp_pkg::OfsW-1:0];
                ubp_pkg::RegRetry: retry_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0; to_reg <= '0; att_reg <= '0; ofs_reg <= '0;
            xor_reg <= '0; left_reg <= '0;
            link_reg <= 1'b0; fail_reg <= 1'b0; boot_reg <= 1'b0;
        end
        else if (go)
        begin
            step_reg <= step_next; to_reg <= to_next; att_reg <= att_next;
            ofs_reg <= ofs_next; xor_reg <= xor_next; left_reg <= left_next;
            link_reg <= link_next; fail_reg <= fail_next; boot_reg <= boot_next;
        end
    end

    always_comb
    begin
        step_next = step_reg; to_next = to_reg; att_next = att_reg;
        ofs_next = ofs_reg; xor_next = xor_reg; left_next = left_reg;
        link_next = link_reg; fail_next = fail_reg; boot_next = boot_reg;
        r = '0;
        addr = base_reg + {{(32-ubp_pkg::OfsW){1'b0}}, ofs_reg};
        rem = (size_reg > ofs_reg) ? size_reg - ofs_reg : '0;
        len = (rem < ubp_pkg::OfsW'(ubp_pkg::PacketBytes)) ? rem[ubp_pkg::LenW-1:0]
              : ubp_pkg::LenW'(ubp_pkg::PacketBytes);
        plen = (len + ubp_pkg::LenW'(3)) & ~ubp_pkg::LenW'(3);
        ofs1 = ofs_reg + 1'b1;
        left1 = left_reg - 1'b1;
        // bytes in current packet = ((ofs1-1) mod P) + 1; pad from low bits
        pad = 2'(3'd4 - {1'b0, ofs_reg[1:0] + 2'd1});
        x = xor_reg ^ in_item.image_byte;
        case (ubp_pkg::mode_t'(in_item.mode))
            ubp_pkg::MODE_START:
            begin
                if (step_reg == ubp_pkg::PH_STOP)
                begin
                    fail_next = 1'b0; link_next = 1'b0; att_next = '0; ofs_next = '0;
                    left_next = '0; xor_next = '0;
                    boot_next = 1'b1; r.pulse = 1'b1;
                    r.bytes[0] = ubp_pkg::SyncCode; r.count = 4'd1;
                    step_next = ubp_pkg::PH_SYNC; to_next = ubp_pkg::ToShort;
                end
            end
            ubp_pkg::MODE_TICK:
            begin
                if (step_reg != ubp_pkg::PH_STOP && step_reg != ubp_pkg::PH_DATA)
                begin
                    if (to_reg != '0)
                        to_next = to_reg - 1'b1;
                    else if (step_reg == ubp_pkg::PH_SYNC && att_reg < retry_reg)
                    begin
                        att_next = att_reg + 1'b1; r.pulse = 1'b1;
                        r.bytes[0] = ubp_pkg::SyncCode; r.count = 4'd1;
                        to_next = ubp_pkg::ToShort;
                    end
                    else
                    begin
                        step_next = '0; fail_next = 1'b1; link_next = 1'b0;
                        boot_next = 1'b0; att_next = '0; ofs_next = '0;
                        left_next = '0; xor_next = '0; to_next = '0;
                    end
                end
            end
            ubp_pkg::MODE_REPLY:
            begin
                if (step_reg == ubp_pkg::PH_SYNC)
                begin
                    if (in_item.reply_byte == ubp_pkg::AckCode ||
                        in_item.reply_byte == ubp_pkg::NackCode)
                    begin
                        link_next = 1'b1; att_next = '0;
                        r.bytes[0] = ubp_pkg::EraseCmd; r.bytes[1] = ubp_pkg::EraseCmdX;
                        r.count = 4'd2;
                        step_next = ubp_pkg::PH_ERASE; to_next = ubp_pkg::ToShort;
                    end
                end
                else if (step_reg != ubp_pkg::PH_STOP && step_reg != ubp_pkg::PH_DATA)
                begin
                    if (in_item.reply_byte != ubp_pkg::AckCode ||
                        (step_reg == ubp_pkg::PH_ADDR && rem == '0))
                    begin
                        step_next = '0; fail_next = 1'b1; link_next = 1'b0;
                        boot_next = 1'b0; att_next = '0; ofs_next = '0;
                        left_next = '0; xor_next = '0; to_next = '0;
                    end
                    else
                    begin
                        case (step_reg)
                            ubp_pkg::PH_ERASE:
                            begin
                                r.bytes[0] = ubp_pkg::EraseAll;
                                r.bytes[1] = ubp_pkg::EraseAllX; r.count = 4'd2;
                                step_next = ubp_pkg::PH_EDONE; to_next = ubp_pkg::ToErase;
                            end
                            ubp_pkg::PH_EDONE, ubp_pkg::PH_DACK:
                            begin
                                r.count = 4'd2; to_next = ubp_pkg::ToShort;
                                if (ofs_reg < size_reg)
                                begin
                                    r.bytes[0] = ubp_pkg::WriteCmd;
                                    r.bytes[1] = ubp_pkg::WriteCmdX;
                                    step_next = ubp_pkg::PH_WCMD;
                                end
                                else
                                begin
                                    r.bytes[0] = ubp_pkg::GoCmd; r.bytes[1] = ubp_pkg::GoCmdX;
                                    step_next = ubp_pkg::PH_GO;
                                end
                            end
                            ubp_pkg::PH_WCMD:
                            begin
                                r.bytes[0] = addr[31:24]; r.bytes[1] = addr[23:16];
                                r.bytes[2] = addr[15:8]; r.bytes[3] = addr[7:0];
                                r.bytes[4] = addr[31:24] ^ addr[23:16] ^ addr[15:8] ^ addr[7:0];
                                r.count = 4'd5;
                                step_next = ubp_pkg::PH_ADDR; to_next = ubp_pkg::ToAddr;
                            end
                            ubp_pkg::PH_ADDR:
                            begin
                                r.bytes[0] = 8'(plen - 1'b1); r.count = 4'd1;
                                xor_next = 8'(plen - 1'b1);
                                left_next = 9'(len);
                                step_next = ubp_pkg::PH_DATA; to_next = '0;
                            end
                            default:
                            begin
                                r.bytes[0] = base_reg[31:24]; r.bytes[1] = base_reg[23:16];
                                r.bytes[2] = base_reg[15:8]; r.bytes[3] = base_reg[7:0];
                                r.bytes[4] = base_reg[31:24] ^ base_reg[23:16]
                                           ^ base_reg[15:8] ^ base_reg[7:0];
                                r.count = 4'd5;
                                step_next = '0; fail_next = 1'b0; link_next = 1'b0;
                                boot_next = 1'b0; att_next = '0; ofs_next = '0;
                                left_next = '0; xor_next = '0; to_next = '0;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                if (step_reg == ubp_pkg::PH_DATA)
                begin
                    r.bytes[0] = in_item.image_byte; r.count = 4'd1;
                    xor_next = x; ofs_next = ofs1; left_next = left1;
                    if (left1 == '0)
                    begin
                        r.bytes[1] = ubp_pkg::PadByte; r.bytes[2] = ubp_pkg::PadByte;
                        r.bytes[3] = ubp_pkg::PadByte;
                        case (pad)
                            2'd1: r.bytes[2] = x ^ ubp_pkg::PadByte;
                            2'd2: r.bytes[3] = x;
                            2'd3: r.bytes[4] = x ^ ubp_pkg::PadByte;
                            default: r.bytes[1] = x;
                        endcase
                        r.count = 4'd2 + {2'b0, pad};
                        step_next = ubp_pkg::PH_DACK;
                        to_next = (ofs1 >= size_reg) ? ubp_pkg::ToLast : ubp_pkg::ToData;
                    end
                end
            end
        endcase
        r.boot0 = boot_next;
        r.want = (step_next == ubp_pkg::PH_DATA);
        r.phase = step_next;
        r.fault = fail_next;
        r.conn = link_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ubp_pkg::PH_STOP) |-> !link_reg)
        else $error("link up while stopped");
    assert property (@(posedge clk) disable iff (!rst_n)
        go && r.pulse |-> r.count == 4'd1)
        else $error("reset pulse without a single sync byte");
    assert property (@(posedge clk) disable iff (!rst_n)
        go |-> r.count <= 4'd5)
        else $error("run too long");
endmodule

### rtl/core/ubp_queue.sv
// Two-entry queue of runs between the front and back parts.
// Depends on ubp_pkg.
module ubp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  ubp_pkg::run_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output ubp_pkg::run_t rd_data
);
    ubp_pkg::run_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
endmodule

### rtl/core/ubp_back.sv
// Back part: plays one run out as one result per cycle while res_ready is high.
// Depends on ubp_pkg.
module ubp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          run_valid,
    output logic          run_ready,
    input  ubp_pkg::run_t run_data,
    output logic          res_valid,
    input  logic          res_ready,
    output ubp_pkg::res_t res_data
);
    logic [2:0] idx_reg;
    logic last;
    logic [3:0] n;

    assign n = (run_data.count == '0) ? 4'd1 : run_data.count;
    assign last = ({1'b0, idx_reg} == n - 4'd1);
    assign res_valid = run_valid;
    assign run_ready = res_ready && last;

    always_comb
    begin
        res_data.tx_byte = (run_data.count == '0) ? 8'h00 : run_data.bytes[idx_reg];
        res_data.tx_valid = run_data.count != '0;
        res_data.last_of_run = last;
        res_data.boot0_level = run_data.boot0;
        res_data.reset_pulse = run_data.pulse;
        res_data.want_image = run_data.want;
        res_data.phase = run_data.phase;
        res_data.fault = run_data.fault;
        res_data.connected = run_data.conn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (res_valid && res_ready)
            idx_reg <= last ? 3'd0 : idx_reg + 3'd1;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid |-> {1'b0, idx_reg} < n)
        else $error("index past run");
endmodule

### rtl/core/uart_bootloader_programmer_top.sv
// Top level of the serial bootloader host.
// Depends on ubp_pkg, ubp_if, ubp_front, ubp_queue and ubp_back.
//
//  channel   | dir | payload
//  in_ch     | in  | mode, reply_byte, image_byte
//  out_ch    | out | tx_byte, tx_valid, last_of_run, status fields
//  cfg_*     | in  | write enable, index, 32-bit data
//
// Each item gives a run of one to five results, which leaves one per cycle while
// out_ch is ready, so the output side sets the throughput.
// The two-entry run queue keeps the input open for one more run while a run drains.
// Reset clears the sequencer and restores register defaults.
module uart_bootloader_programmer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    ubp_if.sink         in_ch,
    ubp_if.source       out_ch
);
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    ubp_pkg::run_t fq_data, qb_data;

    ubp_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_item(in_ch.data), .run_valid(fq_valid), .run_ready(fq_ready),
        .run_data(fq_data)
    );

    ubp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(fq_valid), .wr_ready(fq_ready),
        .wr_data(fq_data), .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
    );

    ubp_back u_back (
        .clk(clk), .rst_n(rst_n), .run_valid(qb_valid), .run_ready(qb_ready),
        .run_data(qb_data), .res_valid(out_ch.valid), .res_ready(out_ch.ready),
        .res_data(out_ch.data)
    );
endmodule
